// File: rtl/dapd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dapd_pkg;

  localparam int SIG_W    = 20;
  localparam int ERR_W    = 21;
  localparam int DEL_W    = 22;
  localparam int INT_W    = 32;
  localparam int GAIN_W   = 23;
  localparam int ACC_W    = 46;
  localparam int MAG_W    = 44;
  localparam int SUM_FRAC = 14;
  localparam int BATT_W   = 14;
  localparam int RECIP_W  = 24;
  localparam int THR_W    = 19;
  localparam int DRV_W    = 24;
  localparam int MK_W     = 4;
  localparam int STEP_W   = 5;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 24;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(3200);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(16777);

  localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

  localparam logic [MAG_W-1:0] Q_POS_LIM = MAG_W'((64'd1 << (DRV_W-1)) - 64'd1);
  localparam logic [MAG_W-1:0] Q_NEG_LIM = MAG_W'(64'd1 << (DRV_W-1));
  localparam logic [DRV_W-1:0] DRV_POS_MAG = {1'b0, {(DRV_W-1){1'b1}}};
  localparam logic [DRV_W-1:0] DRV_NEG_MAG = {1'b1, {(DRV_W-1){1'b0}}};

  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [MK_W-1:0] MK_SPIN_A = MK_W'(2);
  localparam logic [MK_W-1:0] MK_SPIN_B = MK_W'(9);
  localparam logic [MK_W-1:0] MK_SLAL_A = MK_W'(4);
  localparam logic [MK_W-1:0] MK_SLAL_B = MK_W'(6);

  typedef enum logic [CFG_AW-1:0] {
    CFG_THRESH = 1'b0,
    CFG_RECIP  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_UPD,
    ST_LOAD,
    ST_MUL,
    ST_SCL_LOAD,
    ST_SCL_BATT,
    ST_SCL_MID,
    ST_SCL_RECIP,
    ST_SCL_DONE,
    ST_OUT
  } dapd_state_t;

  typedef enum logic [2:0] {
    T_S_P,
    T_S_I,
    T_S_D,
    T_R_P,
    T_R_I,
    T_R_D,
    T_A_P,
    T_A_D
  } term_t;

  typedef struct packed {
    logic [GAIN_W-1:0] sp;
    logic [GAIN_W-1:0] si;
    logic [GAIN_W-1:0] sd;
    logic [GAIN_W-1:0] tp;
    logic [GAIN_W-1:0] ti;
    logic [GAIN_W-1:0] td;
    logic [GAIN_W-1:0] ap;
    logic [GAIN_W-1:0] ad;
  } gain_set_t;

  // unsigned Q9.14 gains, all non-negative
  localparam gain_set_t G_EXPL_BASE = '{
    sp: GAIN_W'(52429), si: GAIN_W'(1311), sd: GAIN_W'(0),
    tp: GAIN_W'(42598), ti: GAIN_W'(1638), td: GAIN_W'(16),
    ap: GAIN_W'(0), ad: GAIN_W'(0)};
  localparam gain_set_t G_EXPL_TURN = '{
    sp: GAIN_W'(52429), si: GAIN_W'(1311), sd: GAIN_W'(0),
    tp: GAIN_W'(39322), ti: GAIN_W'(1638), td: GAIN_W'(0),
    ap: GAIN_W'(4423680), ad: GAIN_W'(16384)};
  localparam gain_set_t G_EXPL_SLAL = '{
    sp: GAIN_W'(52429), si: GAIN_W'(1311), sd: GAIN_W'(0),
    tp: GAIN_W'(42598), ti: GAIN_W'(1638), td: GAIN_W'(16),
    ap: GAIN_W'(819200), ad: GAIN_W'(0)};
  localparam gain_set_t G_FAST_BASE = '{
    sp: GAIN_W'(60621), si: GAIN_W'(1966), sd: GAIN_W'(1638),
    tp: GAIN_W'(47514), ti: GAIN_W'(2163), td: GAIN_W'(0),
    ap: GAIN_W'(1638400), ad: GAIN_W'(1638)};
  localparam gain_set_t G_FAST_K6 = '{
    sp: GAIN_W'(54067), si: GAIN_W'(1638), sd: GAIN_W'(1638),
    tp: GAIN_W'(63898), ti: GAIN_W'(2327), td: GAIN_W'(164),
    ap: GAIN_W'(1474560), ad: GAIN_W'(8192)};

  function automatic gain_set_t pick_gains(input logic profile, input logic [MK_W-1:0] mk);
    gain_set_t g;
    g = G_EXPL_BASE;
    if (!profile) begin
      case (mk) inside
        MK_SPIN_A, MK_SPIN_B: g = G_EXPL_TURN;
        MK_SLAL_A, MK_SLAL_B: g = G_EXPL_SLAL;
        default:              g = G_EXPL_BASE;
      endcase
    end else begin
      case (mk)
        MK_SLAL_B: g = G_FAST_K6;
        default:   g = G_FAST_BASE;
      endcase
    end
    return g;
  endfunction

  function automatic logic [INT_W-1:0] sat_int(input logic [INT_W:0] s);
    logic [INT_W-1:0] r;
    r = s[INT_W-1:0];
    if (s[INT_W] != s[INT_W-1]) begin
      r = s[INT_W] ? INT_MIN : INT_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dapd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dapd_in_if import dapd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [SIG_W-1:0] straight_target;
  logic signed [SIG_W-1:0] turn_rate_target;
  logic signed [SIG_W-1:0] angle_target;
  logic signed [SIG_W-1:0] wheel_speed_right;
  logic signed [SIG_W-1:0] wheel_speed_left;
  logic signed [SIG_W-1:0] filtered_speed;
  logic signed [SIG_W-1:0] gyro_rate;
  logic signed [SIG_W-1:0] yaw_measured;
  logic                    speed_profile;
  logic [MK_W-1:0]         motion_kind;
  logic [BATT_W-1:0]       battery_mv;

  modport source (
    output valid, kind, straight_target, turn_rate_target, angle_target,
           wheel_speed_right, wheel_speed_left, filtered_speed, gyro_rate,
           yaw_measured, speed_profile, motion_kind, battery_mv,
    input  ready
  );

  modport sink (
    input  valid, kind, straight_target, turn_rate_target, angle_target,
           wheel_speed_right, wheel_speed_left, filtered_speed, gyro_rate,
           yaw_measured, speed_profile, motion_kind, battery_mv,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/dapd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dapd_out_if import dapd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] straight_drive;
  logic signed [DRV_W-1:0] turn_drive;

  modport source (
    output valid, straight_drive, turn_drive,
    input  ready
  );

  modport sink (
    input  valid, straight_drive, turn_drive,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/dual_axis_pid_drive.sv
`timescale 1ns / 1ps
`default_nettype none

// the input is turned into errors, deltas and integrals, then
// each of the eight gain products is a shift-add over the gain bits (one bit per cycle),
// and each drive is scaled by a bit-serial multiplier over 14 battery and 24 reciprocal bits
// throughput: one item at a time, the next input is taken the cycle after the result is
// registered; a clear item only zeroes the integrals and gives no result
// reset: synchronous active-low; clears state, integrals, previous errors, output valid

module dual_axis_pid_drive import dapd_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  dapd_in_if.sink           in_item,
  dapd_out_if.source        out_result,
  input  wire               cfg_we,
  input  wire  [CFG_AW-1:0] cfg_addr,
  input  wire  [CFG_DW-1:0] cfg_wdata
);

  dapd_state_t state_r, state_nxt;

  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic [RECIP_W-1:0] recip_r, recip_nxt;

  logic [ERR_W-1:0] s_prev_r, s_prev_nxt;
  logic [ERR_W-1:0] r_prev_r, r_prev_nxt;
  logic [ERR_W-1:0] a_prev_r, a_prev_nxt;
  logic [INT_W-1:0] s_int_r, s_int_nxt;
  logic [INT_W-1:0] r_int_r, r_int_nxt;

  logic [SIG_W-1:0]  s_tgt_r, s_tgt_nxt;
  logic [SIG_W-1:0]  r_tgt_r, r_tgt_nxt;
  logic [SIG_W-1:0]  a_tgt_r, a_tgt_nxt;
  logic [SIG_W-1:0]  wr_r, wr_nxt;
  logic [SIG_W-1:0]  wl_r, wl_nxt;
  logic [SIG_W-1:0]  filt_r, filt_nxt;
  logic [SIG_W-1:0]  gyro_r, gyro_nxt;
  logic [SIG_W-1:0]  yaw_r, yaw_nxt;
  logic [BATT_W-1:0] batt_r, batt_nxt;
  gain_set_t         gains_r, gains_nxt;

  logic [ERR_W-1:0] s_err_r, s_err_nxt;
  logic [ERR_W-1:0] r_err_r, r_err_nxt;
  logic [ERR_W-1:0] a_err_r, a_err_nxt;
  logic [DEL_W-1:0] s_del_r, s_del_nxt;
  logic [DEL_W-1:0] r_del_r, r_del_nxt;
  logic [DEL_W-1:0] a_del_r, a_del_nxt;

  term_t              idx_r, idx_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W-1:0]   mcand_r, mcand_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic [MAG_W-1:0]   hi_r, hi_nxt;
  logic [RECIP_W-1:0] lo_r, lo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               neg_r, neg_nxt;
  logic [DRV_W-1:0]   s_drive_r, s_drive_nxt;
  logic [DRV_W-1:0]   t_drive_r, t_drive_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DRV_W-1:0]   out_s_r, out_s_nxt;
  logic [DRV_W-1:0]   out_t_r, out_t_nxt;

  logic               in_xfer;
  logic [SIG_W:0]     wsum;
  logic [SIG_W-1:0]   s_meas;
  logic               use_wheels;
  logic [ACC_W-1:0]   operand;
  logic [GAIN_W-1:0]  term_gain;
  logic [ACC_W-1:0]   mag_full;
  logic [MAG_W:0]     mul_sum;
  logic               drv_sat;
  logic [DRV_W-1:0]   drv_mag;
  logic [DRV_W-1:0]   drv_val;

  assign in_item.ready             = (state_r == ST_IDLE);
  assign in_xfer                   = in_item.valid && in_item.ready;
  assign out_result.valid          = out_valid_r;
  assign out_result.straight_drive = out_s_r;
  assign out_result.turn_drive     = out_t_r;

  // straight measurement select
  assign wsum       = {wr_r[SIG_W-1], wr_r} + {wl_r[SIG_W-1], wl_r};
  assign use_wheels = $signed({s_tgt_r[SIG_W-1], s_tgt_r}) < $signed({2'b00, thr_r});
  assign s_meas     = use_wheels ? wsum[SIG_W:1] : filt_r;

  always_comb begin
    operand   = '0;
    term_gain = '0;
    unique case (idx_r)
      T_S_P: begin
        operand   = {{(ACC_W-ERR_W){s_err_r[ERR_W-1]}}, s_err_r};
        term_gain = gains_r.sp;
      end
      T_S_I: begin
        operand   = {{(ACC_W-INT_W){s_int_r[INT_W-1]}}, s_int_r};
        term_gain = gains_r.si;
      end
      T_S_D: begin
        operand   = {{(ACC_W-DEL_W){s_del_r[DEL_W-1]}}, s_del_r};
        term_gain = gains_r.sd;
      end
      T_R_P: begin
        operand   = {{(ACC_W-ERR_W){r_err_r[ERR_W-1]}}, r_err_r};
        term_gain = gains_r.tp;
      end
      T_R_I: begin
        operand   = {{(ACC_W-INT_W){r_int_r[INT_W-1]}}, r_int_r};
        term_gain = gains_r.ti;
      end
      T_R_D: begin
        operand   = {{(ACC_W-DEL_W){r_del_r[DEL_W-1]}}, r_del_r};
        term_gain = gains_r.td;
      end
      T_A_P: begin
        operand   = {{(ACC_W-ERR_W){a_err_r[ERR_W-1]}}, a_err_r};
        term_gain = gains_r.ap;
      end
      T_A_D: begin
        operand   = {{(ACC_W-DEL_W){a_del_r[DEL_W-1]}}, a_del_r};
        term_gain = gains_r.ad;
      end
      default: begin
        operand   = '0;
        term_gain = '0;
      end
    endcase
  end

  // drive scaling datapath
  assign mag_full = acc_r[ACC_W-1] ? (ACC_W'(0) - acc_r) : acc_r;
  assign mul_sum  = {1'b0, hi_r}
                    + {1'b0, (lo_r[0] ? mcand_r[MAG_W-1:0] : {MAG_W{1'b0}})};
  assign drv_sat  = neg_r ? (hi_r > Q_NEG_LIM) : (hi_r > Q_POS_LIM);
  assign drv_mag  = drv_sat ? (neg_r ? DRV_NEG_MAG : DRV_POS_MAG) : hi_r[DRV_W-1:0];
  assign drv_val  = neg_r ? (DRV_W'(0) - drv_mag) : drv_mag;

  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = thr_r;
    recip_nxt     = recip_r;
    s_prev_nxt    = s_prev_r;
    r_prev_nxt    = r_prev_r;
    a_prev_nxt    = a_prev_r;
    s_int_nxt     = s_int_r;
    r_int_nxt     = r_int_r;
    s_tgt_nxt     = s_tgt_r;
    r_tgt_nxt     = r_tgt_r;
    a_tgt_nxt     = a_tgt_r;
    wr_nxt        = wr_r;
    wl_nxt        = wl_r;
    filt_nxt      = filt_r;
    gyro_nxt      = gyro_r;
    yaw_nxt       = yaw_r;
    batt_nxt      = batt_r;
    gains_nxt     = gains_r;
    s_err_nxt     = s_err_r;
    r_err_nxt     = r_err_r;
    a_err_nxt     = a_err_r;
    s_del_nxt     = s_del_r;
    r_del_nxt     = r_del_r;
    a_del_nxt     = a_del_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    gain_nxt      = gain_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    step_nxt      = step_r;
    neg_nxt       = neg_r;
    s_drive_nxt   = s_drive_r;
    t_drive_nxt   = t_drive_r;
    out_s_nxt     = out_s_r;
    out_t_nxt     = out_t_r;
    out_valid_nxt = out_valid_r && !out_result.ready;

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_THRESH: thr_nxt   = cfg_wdata[THR_W-1:0];
        CFG_RECIP:  recip_nxt = cfg_wdata[RECIP_W-1:0];
        default:    thr_nxt   = thr_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_item.kind == KIND_CLEAR) begin
            s_int_nxt = '0;
            r_int_nxt = '0;
          end else begin
            s_tgt_nxt = in_item.straight_target;
            r_tgt_nxt = in_item.turn_rate_target;
            a_tgt_nxt = in_item.angle_target;
            wr_nxt    = in_item.wheel_speed_right;
            wl_nxt    = in_item.wheel_speed_left;
            filt_nxt  = in_item.filtered_speed;
            gyro_nxt  = in_item.gyro_rate;
            yaw_nxt   = in_item.yaw_measured;
            batt_nxt  = in_item.battery_mv;
            gains_nxt = pick_gains(in_item.speed_profile, in_item.motion_kind);
            state_nxt = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        s_err_nxt = {s_tgt_r[SIG_W-1], s_tgt_r} - {s_meas[SIG_W-1], s_meas};
        r_err_nxt = {r_tgt_r[SIG_W-1], r_tgt_r} - {gyro_r[SIG_W-1], gyro_r};
        a_err_nxt = {a_tgt_r[SIG_W-1], a_tgt_r} - {yaw_r[SIG_W-1], yaw_r};
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        s_del_nxt  = {s_err_r[ERR_W-1], s_err_r} - {s_prev_r[ERR_W-1], s_prev_r};
        r_del_nxt  = {r_err_r[ERR_W-1], r_err_r} - {r_prev_r[ERR_W-1], r_prev_r};
        a_del_nxt  = {a_err_r[ERR_W-1], a_err_r} - {a_prev_r[ERR_W-1], a_prev_r};
        s_prev_nxt = s_err_r;
        r_prev_nxt = r_err_r;
        a_prev_nxt = a_err_r;
        s_int_nxt  = sat_int({s_int_r[INT_W-1], s_int_r}
                     + {{(INT_W+1-ERR_W){s_err_r[ERR_W-1]}}, s_err_r});
        r_int_nxt  = sat_int({r_int_r[INT_W-1], r_int_r}
                     + {{(INT_W+1-ERR_W){r_err_r[ERR_W-1]}}, r_err_r});
        acc_nxt    = '0;
        idx_nxt    = T_S_P;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        mcand_nxt = operand;
        gain_nxt  = term_gain;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (gain_r == '0) begin
          if (idx_r == T_S_D || idx_r == T_A_D) begin
            state_nxt = ST_SCL_LOAD;
          end else begin
            idx_nxt   = term_t'(idx_r + 3'd1);
            state_nxt = ST_LOAD;
          end
        end else begin
          if (gain_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt = {mcand_r[ACC_W-2:0], 1'b0};
          gain_nxt  = {1'b0, gain_r[GAIN_W-1:1]};
        end
      end
      ST_SCL_LOAD: begin
        neg_nxt   = acc_r[ACC_W-1];
        mcand_nxt = {{(ACC_W-MAG_W+SUM_FRAC){1'b0}}, mag_full[MAG_W-1:SUM_FRAC]};
        hi_nxt    = '0;
        lo_nxt    = {{(RECIP_W-BATT_W){1'b0}}, batt_r};
        step_nxt  = '0;
        state_nxt = ST_SCL_BATT;
      end
      ST_SCL_BATT: begin
        hi_nxt   = mul_sum[MAG_W:1];
        lo_nxt   = {mul_sum[0], lo_r[RECIP_W-1:1]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(BATT_W-1)) begin
          state_nxt = ST_SCL_MID;
        end
      end
      ST_SCL_MID: begin
        // product of magnitude and battery, known below 2^44
        mcand_nxt = {{(ACC_W-MAG_W){1'b0}}, hi_r[MAG_W-BATT_W-1:0],
                     lo_r[RECIP_W-1:RECIP_W-BATT_W]};
        hi_nxt    = '0;
        lo_nxt    = recip_r;
        step_nxt  = '0;
        state_nxt = ST_SCL_RECIP;
      end
      ST_SCL_RECIP: begin
        hi_nxt   = mul_sum[MAG_W:1];
        lo_nxt   = {mul_sum[0], lo_r[RECIP_W-1:1]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(RECIP_W-1)) begin
          state_nxt = ST_SCL_DONE;
        end
      end
      ST_SCL_DONE: begin
        if (idx_r == T_S_D) begin
          s_drive_nxt = drv_val;
          acc_nxt     = '0;
          idx_nxt     = T_R_P;
          state_nxt   = ST_LOAD;
        end else begin
          t_drive_nxt = drv_val;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_result.ready) begin
          out_s_nxt     = s_drive_r;
          out_t_nxt     = t_drive_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      recip_r     <= RECIP_RESET;
      s_prev_r    <= '0;
      r_prev_r    <= '0;
      a_prev_r    <= '0;
      s_int_r     <= '0;
      r_int_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      recip_r     <= recip_nxt;
      s_prev_r    <= s_prev_nxt;
      r_prev_r    <= r_prev_nxt;
      a_prev_r    <= a_prev_nxt;
      s_int_r     <= s_int_nxt;
      r_int_r     <= r_int_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_tgt_r   <= s_tgt_nxt;
    r_tgt_r   <= r_tgt_nxt;
    a_tgt_r   <= a_tgt_nxt;
    wr_r      <= wr_nxt;
    wl_r      <= wl_nxt;
    filt_r    <= filt_nxt;
    gyro_r    <= gyro_nxt;
    yaw_r     <= yaw_nxt;
    batt_r    <= batt_nxt;
    gains_r   <= gains_nxt;
    s_err_r   <= s_err_nxt;
    r_err_r   <= r_err_nxt;
    a_err_r   <= a_err_nxt;
    s_del_r   <= s_del_nxt;
    r_del_r   <= r_del_nxt;
    a_del_r   <= a_del_nxt;
    idx_r     <= idx_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    gain_r    <= gain_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    step_r    <= step_nxt;
    neg_r     <= neg_nxt;
    s_drive_r <= s_drive_nxt;
    t_drive_r <= t_drive_nxt;
    out_s_r   <= out_s_nxt;
    out_t_r   <= out_t_nxt;
  end

`ifndef SYNTHESIS
  a_clear_zeroes_integrals: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_item.kind == KIND_CLEAR) |=> (s_int_r == '0 && r_int_r == '0))
    else $error("integrals not cleared after clear transfer");

  a_scale_after_last_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCL_LOAD) |-> (idx_r == T_S_D || idx_r == T_A_D))
    else $error("scaling started in the middle of a loop sum");

  a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCL_LOAD) |-> (acc_r[ACC_W-1] == acc_r[ACC_W-2]))
    else $error("loop sum exceeds accumulator range");

  a_batt_product_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCL_MID) |-> (hi_r[MAG_W-1:MAG_W-BATT_W] == '0))
    else $error("battery product wider than expected");
`endif

endmodule

`default_nettype wire

// File: test/dapd_drive_checker.sv
`timescale 1ns / 1ps

module dapd_drive_checker import dapd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dapd_in_if                in_ch,
  dapd_out_if               out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic signed [DRV_W-1:0] straight;
    logic signed [DRV_W-1:0] turn;
  } drive_pair_t;

  typedef struct {
    longint sp, si, sd, tp, ti, td, ap, ad;
  } gain_row_t;

  drive_pair_t      drive_q[$];
  logic [THR_W-1:0] switch_thr;
  logic [RECIP_W-1:0] fs_recip;
  longint           s_prev, s_acc, r_prev, r_acc, a_prev;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic gain_row_t gains_for(input logic profile, input logic [MK_W-1:0] mk);
    gain_row_t g;
    if (!profile) begin
      g = '{52429, 1311, 0, 42598, 1638, 16, 0, 0};
      if (mk == MK_SPIN_A || mk == MK_SPIN_B) begin
        g.tp = 39322;
        g.td = 0;
        g.ap = 4423680;
        g.ad = 16384;
      end else if (mk == MK_SLAL_A || mk == MK_SLAL_B) begin
        g.ap = 819200;
      end
    end else if (mk == MK_SLAL_B) begin
      g = '{54067, 1638, 1638, 63898, 2327, 164, 1474560, 8192};
    end else begin
      g = '{60621, 1966, 1638, 47514, 2163, 0, 1638400, 1638};
    end
    return g;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // magnitude scaled by battery and reciprocal, truncated toward zero, saturated to drive range
  function automatic logic [DRV_W-1:0] scale_drive(input longint sum,
                                                   input logic [BATT_W-1:0] batt,
                                                   input logic [RECIP_W-1:0] recip);
    logic        neg;
    logic [63:0] mag, m, q, lim;
    logic [95:0] prod;
    neg = (sum < 0);
    mag = neg ? 64'(-sum) : 64'(sum);
    m = (mag >> SUM_FRAC) * 64'(batt);
    if (m > (64'd1 << 48)) m = 64'd1 << 48;
    prod = 96'(m) * 96'(recip);
    q = 64'(prod >> 24);
    lim = neg ? (64'd1 << (DRV_W-1)) : (64'd1 << (DRV_W-1)) - 64'd1;
    if (q > lim) q = lim;
    return neg ? DRV_W'(64'd0 - q) : DRV_W'(q);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic predict_tick();
    gain_row_t   g;
    longint      st, meas, s_err, s_del, r_err, r_del, a_err, a_del, s_sum, t_sum;
    drive_pair_t d;
    g = gains_for(in_ch.speed_profile, in_ch.motion_kind);
    st = longint'(in_ch.straight_target);
    if (st < longint'(switch_thr)) begin
      meas = (longint'(in_ch.wheel_speed_right) + longint'(in_ch.wheel_speed_left)) >>> 1;
    end else begin
      meas = longint'(in_ch.filtered_speed);
    end
    s_err = st - meas;
    s_del = s_err - s_prev;
    s_prev = s_err;
    s_acc = clamp32(s_acc + s_err);
    s_sum = g.sp * s_err + g.si * s_acc + g.sd * s_del;

    r_err = longint'(in_ch.turn_rate_target) - longint'(in_ch.gyro_rate);
    r_del = r_err - r_prev;
    r_prev = r_err;
    r_acc = clamp32(r_acc + r_err);
    t_sum = g.tp * r_err + g.ti * r_acc + g.td * r_del;

    a_err = longint'(in_ch.angle_target) - longint'(in_ch.yaw_measured);
    a_del = a_err - a_prev;
    a_prev = a_err;
    t_sum += g.ap * a_err + g.ad * a_del;

    d.straight = scale_drive(s_sum, in_ch.battery_mv, fs_recip);
    d.turn = scale_drive(t_sum, in_ch.battery_mv, fs_recip);
    drive_q.push_back(d);
  endtask

  always @(posedge clk) begin
    drive_pair_t want;
    if (!rst_n) begin
      switch_thr = THR_RESET;
      fs_recip = RECIP_RESET;
      s_prev = 0;
      s_acc = 0;
      r_prev = 0;
      r_acc = 0;
      a_prev = 0;
      drive_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = drive_q.pop_front();
          if (out_ch.straight_drive !== want.straight) begin
            report_mismatch($sformatf("straight_drive got %0d want %0d",
                                      out_ch.straight_drive, want.straight));
          end
          if (out_ch.turn_drive !== want.turn) begin
            report_mismatch($sformatf("turn_drive got %0d want %0d",
                                      out_ch.turn_drive, want.turn));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_CLEAR) begin
          s_acc = 0;
          r_acc = 0;
        end else begin
          predict_tick();
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_THRESH: switch_thr = cfg_wdata[THR_W-1:0];
          CFG_RECIP:  fs_recip = cfg_wdata[RECIP_W-1:0];
          default:    ;
        endcase
      end
    end
    pending = drive_q.size();
  end

endmodule

// File: test/tb_dual_axis_pid_drive.sv
`timescale 1ns / 1ps

module tb_dual_axis_pid_drive;
  import dapd_pkg::*;

  localparam logic KIND_TICK = ~KIND_CLEAR;
  localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  typedef struct {
    logic                    kind;
    logic signed [SIG_W-1:0] st, rt, at, wr, wl, filt, gyro, yaw;
    logic                    prof;
    logic [MK_W-1:0]         mk;
    logic [BATT_W-1:0]       batt;
  } tick_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  bit                calm;
  logic [THR_W-1:0]  thr_now;

  dapd_in_if  in_ch ();
  dapd_out_if out_ch ();

  dual_axis_pid_drive DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_ch),
    .out_result (out_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  dapd_drive_checker u_drive_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [MK_W-1:0] special_mk(input int i);
    case (i % 4)
      0:       return MK_SPIN_A;
      1:       return MK_SPIN_B;
      2:       return MK_SLAL_A;
      default: return MK_SLAL_B;
    endcase
  endfunction

  function automatic logic signed [SIG_W-1:0] rand_sig();
    case ($urandom_range(0, 5))
      0, 1:    return SIG_W'($urandom);
      2:       return $urandom_range(0, 1) ? SIG_MAX : SIG_MIN;
      3:       return SIG_W'(int'($urandom_range(0, 8000)) - 4000);
      default: return SIG_W'(int'($urandom_range(0, 1600)) - 800);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.kind = ($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_TICK;
    t.st = ($urandom_range(0, 5) == 0) ? SIG_W'(int'(thr_now) + int'($urandom_range(0, 4)) - 2)
                                       : rand_sig();
    t.rt = rand_sig();
    t.at = rand_sig();
    t.wr = rand_sig();
    t.wl = rand_sig();
    t.filt = rand_sig();
    t.gyro = rand_sig();
    t.yaw = rand_sig();
    t.prof = 1'($urandom);
    t.mk = $urandom_range(0, 1) ? special_mk($urandom_range(0, 3)) : MK_W'($urandom);
    case ($urandom_range(0, 7))
      0:       t.batt = '0;
      1:       t.batt = '1;
      2, 3:    t.batt = BATT_W'($urandom);
      default: t.batt = BATT_W'($urandom_range(6000, 8400));
    endcase
    return t;
  endfunction

  function automatic tick_t quiet_tick();
    tick_t t;
    t = '{kind: KIND_TICK, st: '0, rt: '0, at: '0, wr: '0, wl: '0, filt: '0, gyro: '0,
          yaw: '0, prof: 1'b0, mk: '0, batt: BATT_W'(7400)};
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= t.kind;
    in_ch.straight_target <= t.st;
    in_ch.turn_rate_target <= t.rt;
    in_ch.angle_target <= t.at;
    in_ch.wheel_speed_right <= t.wr;
    in_ch.wheel_speed_left <= t.wl;
    in_ch.filtered_speed <= t.filt;
    in_ch.gyro_rate <= t.gyro;
    in_ch.yaw_measured <= t.yaw;
    in_ch.speed_profile <= t.prof;
    in_ch.motion_kind <= t.mk;
    in_ch.battery_mv <= t.batt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // block is idle once every result is back and a clear has had time to finish
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(input logic [THR_W-1:0] thr, input logic [RECIP_W-1:0] recip);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_THRESH;
    cfg_wdata <= CFG_DW'(thr);
    @(posedge clk);
    cfg_addr <= CFG_RECIP;
    cfg_wdata <= CFG_DW'(recip);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_now = thr;
  endtask

  // result side stalls
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    tick_t t;
    calm = 1'b0;
    thr_now = THR_RESET;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_THRESH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.straight_target <= '0;
    in_ch.turn_rate_target <= '0;
    in_ch.angle_target <= '0;
    in_ch.wheel_speed_right <= '0;
    in_ch.wheel_speed_left <= '0;
    in_ch.filtered_speed <= '0;
    in_ch.gyro_rate <= '0;
    in_ch.yaw_measured <= '0;
    in_ch.speed_profile <= 1'b0;
    in_ch.motion_kind <= '0;
    in_ch.battery_mv <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    t = quiet_tick();
    t.st = SIG_MAX; t.rt = SIG_MAX; t.at = SIG_MAX; t.wr = SIG_MAX; t.wl = SIG_MAX;
    t.filt = SIG_MAX; t.gyro = SIG_MAX; t.yaw = SIG_MAX; t.batt = '1;
    send_tick(t);
    t.st = SIG_MIN; t.rt = SIG_MIN; t.at = SIG_MIN; t.wr = SIG_MIN; t.wl = SIG_MIN;
    t.filt = SIG_MIN; t.gyro = SIG_MIN; t.yaw = SIG_MIN; t.prof = 1'b1; t.mk = '1;
    send_tick(t);
    t = quiet_tick();
    t.st = SIG_MAX; t.filt = SIG_MIN; t.rt = SIG_MIN; t.gyro = SIG_MAX; t.batt = '0;
    send_tick(t);
    t.batt = '1;
    send_tick(t);
    for (int i = 0; i < 8; i++) begin
      t = rand_tick();
      t.kind = KIND_TICK;
      t.prof = (i >= 4);
      t.mk = special_mk(i);
      send_tick(t);
    end
    // wheel mean below threshold with odd negative sum, then filtered at threshold
    t = quiet_tick();
    t.st = SIG_W'(thr_now) - 1'sb1;
    t.wr = -SIG_W'(3);
    t.wl = '0;
    t.filt = SIG_W'(500);
    send_tick(t);
    t.st = SIG_W'(thr_now);
    send_tick(t);
    t.kind = KIND_CLEAR;
    send_tick(t);
    send_tick(t);
    t.kind = KIND_TICK;
    t.prof = 1'b1;
    send_tick(t);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_regs('0, RECIP_W'(1));
        1:       set_regs('1, '1);
        2:       set_regs(THR_RESET, RECIP_RESET);
        3:       set_regs(THR_W'(120), '1);
        default: set_regs(THR_W'($urandom), RECIP_W'($urandom_range(1, 24'hFFFFFF)));
      endcase
      for (int i = 0; i < 80; i++) begin
        if (i % 16 == 0) calm = ($urandom_range(0, 3) == 0);
        send_tick(rand_tick());
      end
      wait_idle();
    end

    // push both integrals hard one way, then clear and reverse
    set_regs(THR_RESET, RECIP_RESET);
    calm = 1'b1;
    for (int i = 0; i < 16; i++) begin
      t = rand_tick();
      t.kind = KIND_TICK;
      t.st = SIG_MAX;
      t.filt = SIG_MIN;
      t.rt = SIG_MIN;
      t.gyro = SIG_MAX;
      send_tick(t);
    end
    t.kind = KIND_CLEAR;
    send_tick(t);
    calm = 1'b0;
    for (int i = 0; i < 6; i++) begin
      t = rand_tick();
      t.kind = KIND_TICK;
      t.st = SIG_MIN;
      t.wr = SIG_MAX;
      t.wl = SIG_MAX;
      t.rt = SIG_MAX;
      t.gyro = SIG_MIN;
      send_tick(t);
    end
    wait_idle();
    repeat (200) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dapd_pkg.sv
rtl/dapd_in_if.sv
rtl/dapd_out_if.sv
rtl/dual_axis_pid_drive.sv
test/dapd_drive_checker.sv
test/tb_dual_axis_pid_drive.sv
